>>> rtl/pstc_pkg.sv
// shared types, register indexes and constants for the temperature compensation block
package pstc_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgAc5     = 3'd0;
  localparam logic [2:0] CfgAc6     = 3'd1;
  localparam logic [2:0] CfgMc      = 3'd2;
  localparam logic [2:0] CfgMd      = 3'd3;
  localparam logic [2:0] CfgTempMin = 3'd4;
  localparam logic [2:0] CfgTempMax = 3'd5;
  localparam logic [2:0] CfgReady   = 3'd6;

  // reset values, hundredths of a degree
  localparam logic signed [15:0] TempMinReset  = -16'sd4000;
  localparam logic signed [15:0] TempMaxReset  = 16'sd12500;
  localparam logic signed [15:0] LastTempReset = 16'sd2500;

  // divider sizing: dividend is mc shifted left by 11
  localparam int unsigned McShift  = 11;
  localparam int unsigned DivBits  = 16 + McShift;
  localparam int unsigned DsrBits  = 19;
  localparam int unsigned CntBits  = $clog2(DivBits);

  typedef struct packed {
    logic [15:0] raw_temp;
    logic        read_ok;
  } pstc_in_t;

  typedef struct packed {
    logic signed [15:0] temp_hundredths;
    logic               fresh;
    logic               div_fault;
  } pstc_out_t;

  typedef struct packed {
    logic [15:0]        cal_ac5;
    logic [15:0]        cal_ac6;
    logic signed [15:0] cal_mc;
    logic signed [15:0] cal_md;
    logic signed [15:0] temp_min;
    logic signed [15:0] temp_max;
    logic               sensor_ready;
  } pstc_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_start;
    logic sum_en;
    logic fin_en;
    logic fresh;
    logic fault;
  } pstc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_zero;
    logic div_done;
  } pstc_sts_t;

endpackage

>>> rtl/pstc_div.sv
// bit-serial signed divider, quotient truncated toward zero
module pstc_div
  import pstc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DivBits-1:0] dividend_i,
  input  logic signed [DsrBits-1:0] divisor_i,
  output logic signed [DivBits:0]   quot_o,
  output logic                      done_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DivBits-1:0] quo_q, quo_d;
  logic [DsrBits-1:0] rem_q, rem_d;
  logic [DsrBits-1:0] dsr_q, dsr_d;
  logic               neg_q, neg_d;
  logic [DsrBits:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[DivBits-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DivBits-1] ? (~dividend_i + DivBits'(1)) : dividend_i;
      dsr_d  = divisor_i[DsrBits-1] ? (~divisor_i + DsrBits'(1)) : divisor_i;
      neg_d  = dividend_i[DivBits-1] ^ divisor_i[DsrBits-1];
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits back in DsrBits
      rem_d = ge ? DsrBits'(rem_sh - {1'b0, dsr_q}) : rem_sh[DsrBits-1:0];
      quo_d = {quo_q[DivBits-2:0], ge};
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(DivBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign done_o = done_q;

endmodule

>>> rtl/pstc_dp.sv
// compensation datapath: offset multiply, divide, scale, saturate and clamp
module pstc_dp
  import pstc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pstc_cfg_t   cfg_i,
  input  pstc_cmd_t   cmd_i,
  input  logic [15:0] raw_temp_i,
  output pstc_sts_t   sts_o,
  output pstc_out_t   out_data_o
);

  logic [15:0]               raw_q;
  logic signed [17:0]        x1_q;
  logic signed [15:0]        tsat_q;
  logic signed [15:0]        last_q, last_d;
  pstc_out_t                 out_q;

  logic signed [16:0]        diff;
  logic signed [33:0]        prod;
  logic signed [DsrBits-1:0] divisor;
  logic signed [DivBits-1:0] dividend;
  logic signed [DivBits:0]   quot;
  logic                      div_done;
  logic signed [28:0]        sum;
  logic signed [28:0]        shr;
  logic signed [28:0]        tval;
  logic signed [15:0]        tsat_d;
  logic signed [15:0]        pick;

  assign diff = $signed({1'b0, raw_q}) - $signed({1'b0, cfg_i.cal_ac6});
  assign prod = diff * $signed({1'b0, cfg_i.cal_ac5});

  assign divisor  = $signed({x1_q[17], x1_q}) + $signed({{3{cfg_i.cal_md[15]}}, cfg_i.cal_md});
  assign dividend = $signed({cfg_i.cal_mc, {McShift{1'b0}}});

  pstc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // floor of (x1 + x2 + 8) / 16, then times ten as two shifts
  assign sum  = $signed({{11{x1_q[17]}}, x1_q}) + $signed({quot[DivBits], quot}) + 29'sd8;
  assign shr  = sum >>> 4;
  assign tval = (shr <<< 3) + (shr <<< 1);

  always_comb begin
    if (tval > 29'sd32767) begin
      tsat_d = 16'sd32767;
    end else if (tval < -29'sd32768) begin
      tsat_d = -16'sd32768;
    end else begin
      tsat_d = tval[15:0];
    end
  end

  // upper limit is tested first so crossed limits resolve to temp_max
  always_comb begin
    pick = cmd_i.fresh ? tsat_q : last_q;
    if (pick > cfg_i.temp_max) begin
      last_d = cfg_i.temp_max;
    end else if (pick < cfg_i.temp_min) begin
      last_d = cfg_i.temp_min;
    end else begin
      last_d = pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LastTempReset;
    end else if (cmd_i.fin_en) begin
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= raw_temp_i;
    end
    if (cmd_i.mul_en) begin
      x1_q <= prod[32:15];
    end
    if (cmd_i.sum_en) begin
      tsat_q <= tsat_d;
    end
    if (cmd_i.fin_en) begin
      out_q.temp_hundredths <= last_d;
      out_q.fresh           <= cmd_i.fresh;
      out_q.div_fault       <= cmd_i.fault;
    end
  end

  assign sts_o.div_zero = (divisor == '0);
  assign sts_o.div_done = div_done;
  assign out_data_o     = out_q;

endmodule

>>> rtl/pstc_ctrl.sv
// sequencing state machine and output handshake
module pstc_ctrl
  import pstc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      read_ok_i,
  input  logic      sensor_ready_i,
  input  logic      out_stall_i,
  input  pstc_sts_t sts_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output pstc_cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fresh_q, fresh_d;
  logic       fault_q, fault_d;
  logic       oval_q, oval_d;
  logic       out_free;

  assign out_free = !oval_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    fresh_d   = fresh_q;
    fault_d   = fault_q;
    cmd_o     = '0;
    cmd_o.fresh = fresh_q;
    cmd_o.fault = fault_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fresh_d    = 1'b0;
          fault_d    = 1'b0;
          // items taken while the sensor is not ready are dropped
          if (sensor_ready_i) begin
            state_d = read_ok_i ? StMul : StFin;
          end
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StChk;
      end
      StChk: begin
        if (sts_i.div_zero) begin
          fault_d = 1'b1;
          state_d = StFin;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StSum;
        end
      end
      StSum: begin
        cmd_o.sum_en = 1'b1;
        fresh_d      = 1'b1;
        state_d      = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.fin_en = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.fin_en) begin
      oval_d = 1'b1;
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end else begin
      oval_d = oval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fresh_q <= 1'b0;
      fault_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      fault_q <= fault_d;
      oval_q  <= oval_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = oval_q;

endmodule

>>> rtl/pressure_sensor_temp_compensation.sv
// Temperature compensation top level: config registers, controller and datapath.
// A good reading passes the multiply, divisor check, 27-iteration bit-serial divide,
// sum and finish states; a failed read goes straight to finish, a zero divisor skips
// the divide. One item is in work at a time; the next waits until the last is done.
// Reset: calibration and ready clear, limits -4000 / 12500, last value 2500.
module pressure_sensor_temp_compensation
  import pstc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pstc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pstc_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  pstc_cfg_t cfg_q;
  pstc_cmd_t cmd;
  pstc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_ac5      <= '0;
      cfg_q.cal_ac6      <= '0;
      cfg_q.cal_mc       <= '0;
      cfg_q.cal_md       <= '0;
      cfg_q.temp_min     <= TempMinReset;
      cfg_q.temp_max     <= TempMaxReset;
      cfg_q.sensor_ready <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgAc5:     cfg_q.cal_ac5      <= cfg_data_i;
        CfgAc6:     cfg_q.cal_ac6      <= cfg_data_i;
        CfgMc:      cfg_q.cal_mc       <= $signed(cfg_data_i);
        CfgMd:      cfg_q.cal_md       <= $signed(cfg_data_i);
        CfgTempMin: cfg_q.temp_min     <= $signed(cfg_data_i);
        CfgTempMax: cfg_q.temp_max     <= $signed(cfg_data_i);
        CfgReady:   cfg_q.sensor_ready <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  pstc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .read_ok_i      (in_data_i.read_ok),
    .sensor_ready_i (cfg_q.sensor_ready),
    .out_stall_i    (out_stall_i),
    .sts_i          (sts),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .cmd_o          (cmd)
  );

  pstc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .raw_temp_i (in_data_i.raw_temp),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> test/tb_top.sv
// testbench for the temperature compensation block: random and directed readings vs a model
`timescale 1ns / 100ps

class temp_comp_board;
  pstc_pkg::pstc_out_t expected_q[$];
  logic [15:0]         ac5, ac6;
  logic signed [15:0]  mc, md, tmin, tmax, last_temp;
  bit                  ready;
  int                  mismatches, results_seen, fresh_seen, fault_seen;

  function new();
    ac5 = '0;
    ac6 = '0;
    mc = '0;
    md = '0;
    tmin = pstc_pkg::TempMinReset;
    tmax = pstc_pkg::TempMaxReset;
    ready = 1'b0;
    last_temp = pstc_pkg::LastTempReset;
    mismatches = 0;
    results_seen = 0;
    fresh_seen = 0;
    fault_seen = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      pstc_pkg::CfgAc5:     ac5 = val;
      pstc_pkg::CfgAc6:     ac6 = val;
      pstc_pkg::CfgMc:      mc = val;
      pstc_pkg::CfgMd:      md = val;
      pstc_pkg::CfgTempMin: tmin = val;
      pstc_pkg::CfgTempMax: tmax = val;
      pstc_pkg::CfgReady:   ready = val[0];
      default: ;
    endcase
  endfunction

  // compensate one reading and queue the result it should produce
  function void note_reading(pstc_pkg::pstc_in_t d);
    longint x1, dvsr, x2, t;
    pstc_pkg::pstc_out_t r;
    if (!ready) return;
    r.fresh = 1'b0;
    r.div_fault = 1'b0;
    if (d.read_ok) begin
      x1 = ((longint'(d.raw_temp) - longint'(ac6)) * longint'(ac5)) >>> 15;
      dvsr = x1 + longint'(md);
      if (dvsr == 0) begin
        r.div_fault = 1'b1;
      end else begin
        x2 = (longint'(mc) * 2048) / dvsr;
        t = ((x1 + x2 + 8) >>> 4) * 10;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        last_temp = t[15:0];
        r.fresh = 1'b1;
      end
    end
    // upper limit wins when the limits are crossed
    if (last_temp > tmax) last_temp = tmax;
    else if (last_temp < tmin) last_temp = tmin;
    r.temp_hundredths = last_temp;
    expected_q.push_back(r);
  endfunction

  function void check_result(pstc_pkg::pstc_out_t got);
    pstc_pkg::pstc_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result temp %0d fresh %0b div_fault %0b", $time,
                 $signed(got.temp_hundredths), got.fresh, got.div_fault);
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    if (want.fresh) fresh_seen++;
    if (want.div_fault) fault_seen++;
    if (got.temp_hundredths !== want.temp_hundredths || got.fresh !== want.fresh ||
        got.div_fault !== want.div_fault) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch temp exp %0d got %0d, fresh exp %0b got %0b, div_fault exp %0b got %0b",
                 $time, $signed(want.temp_hundredths), $signed(got.temp_hundredths),
                 want.fresh, got.fresh, want.div_fault, got.div_fault);
    end
  endfunction
endclass

module tb_top;
  import pstc_pkg::*;

  localparam int DrainCycles = 40;
  localparam int LongHold    = 400;
  localparam int RandPhases  = 11;
  localparam int PhaseItems  = 110;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  pstc_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  pstc_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  bit tx_idle_en;
  bit rx_idle_en;
  bit long_hold_req;
  int settings_used;

  temp_comp_board sb = new();

  pressure_sensor_temp_compensation uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // results are checked before the same edge's input is noted
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_reading(in_data_i);
  end

  // receiver back-pressure
  initial begin : rx_stall_gen
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i = 1'b1;
        for (n = 0; n < LongHold; n++) @(negedge clk_i);
        out_stall_i = 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic pstc_in_t reading(input int raw, input bit ok);
    pstc_in_t d;
    d.raw_temp = 16'(raw);
    d.read_ok = ok;
    return d;
  endfunction

  function automatic pstc_cfg_t mk_cfg(input int ac5, input int ac6, input int mc, input int md,
                                       input int tmin, input int tmax, input bit rdy);
    pstc_cfg_t c;
    c.cal_ac5 = 16'(ac5);
    c.cal_ac6 = 16'(ac6);
    c.cal_mc = 16'(mc);
    c.cal_md = 16'(md);
    c.temp_min = 16'(tmin);
    c.temp_max = 16'(tmax);
    c.sensor_ready = rdy;
    return c;
  endfunction

  function automatic logic [15:0] cal_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // kind 0: plausible calibration, 1: anything, 2: divisor easy to zero
  function automatic pstc_cfg_t rand_cal(input int kind, input bit rdy);
    pstc_cfg_t c;
    int lo, hi, sw;
    case (kind)
      0: begin
        c.cal_ac5 = 16'($urandom_range(20000, 35000));
        c.cal_ac6 = 16'($urandom_range(15000, 30000));
        sw = $urandom_range(5000, 12000);
        c.cal_mc = 16'(-sw);
        c.cal_md = 16'($urandom_range(1500, 4000));
      end
      1: begin
        c.cal_ac5 = cal_word();
        c.cal_ac6 = cal_word();
        c.cal_mc = cal_word();
        c.cal_md = cal_word();
      end
      default: begin
        c.cal_ac5 = 16'h8000;
        c.cal_ac6 = 16'($urandom);
        c.cal_mc = cal_word();
        sw = $urandom_range(0, 2000);
        c.cal_md = 16'(sw - 1000);
      end
    endcase
    lo = int'($urandom_range(0, 65535)) - 32768;
    hi = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0: begin
        lo = -4000;
        hi = 12500;
      end
      1: begin
        lo = -32768;
        hi = 32767;
      end
      2: if (lo > hi) begin
        sw = lo;
        lo = hi;
        hi = sw;
      end
      default: ; // limits may come out crossed
    endcase
    c.temp_min = 16'(lo);
    c.temp_max = 16'(hi);
    c.sensor_ready = rdy;
    return c;
  endfunction

  function automatic pstc_in_t rand_reading(input int kind, input pstc_cfg_t c);
    int v;
    v = int'($urandom_range(0, 65535));
    if (kind == 0) v = int'(c.cal_ac6) + int'($urandom_range(0, 16000)) - 8000;
    // with ac5 at 2^15 this raw value makes the divisor zero
    else if (kind == 2 && $urandom_range(0, 2) == 0) v = int'(c.cal_ac6) - int'(c.cal_md);
    if (v < 0 || v > 65535 || $urandom_range(0, 4) == 0) v = int'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) == 0) v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    return reading(v, $urandom_range(0, 6) != 0);
  endfunction

  // called at a falling edge; returns at a falling edge with cfg_valid_i still high
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input pstc_cfg_t c);
    write_reg(CfgAc5, c.cal_ac5);
    write_reg(CfgAc6, c.cal_ac6);
    write_reg(CfgMc, c.cal_mc);
    write_reg(CfgMd, c.cal_md);
    write_reg(CfgTempMin, c.temp_min);
    write_reg(CfgTempMax, c.temp_max);
    write_reg(CfgReady, {15'd0, c.sensor_ready});
    cfg_valid_i = 1'b0;
    settings_used++;
  endtask

  task automatic send_reading(input pstc_in_t d, input bit allow_gap);
    in_valid_i = 1'b1;
    in_data_i = d;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (allow_gap && tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      in_data_i = pstc_in_t'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  task automatic wait_results();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // ignored readings leave no expectation, so give the block time to finish them too
  task automatic drain_results();
    wait_results();
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin : main_seq
    pstc_cfg_t c;
    int kind, n, ph, i;
    bit last_ph;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgAc5;
    cfg_data_i = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    long_hold_req = 1'b0;
    settings_used = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // not ready out of reset: nothing comes back
    send_reading(reading(0, 0), 1'b1);
    send_reading(reading(65535, 1), 1'b1);
    drain_results();

    // plausible calibration, reset limits
    program_regs(mk_cfg(32757, 23153, -8711, 2868, -4000, 12500, 1'b1));
    send_reading(reading(27898, 1), 1'b1);
    send_reading(reading(0, 1), 1'b1);
    send_reading(reading(65535, 1), 1'b1);
    send_reading(reading(23153, 1), 1'b1);
    send_reading(reading(30000, 0), 1'b1);
    send_reading(reading(40000, 1), 1'b1);
    drain_results();

    // zero divisor: x1 = raw - ac6 and md cancels it at raw 1500
    program_regs(mk_cfg(32768, 1000, 1234, -500, -32768, 32767, 1'b1));
    send_reading(reading(1500, 1), 1'b1);
    send_reading(reading(1501, 1), 1'b1);
    send_reading(reading(1500, 0), 1'b1);
    send_reading(reading(1500, 1), 1'b1);
    drain_results();

    // divisor of +1 and -1 push T past the 16-bit range both ways
    program_regs(mk_cfg(32768, 1, 32767, 0, -32768, 32767, 1'b1));
    send_reading(reading(2, 1), 1'b1);
    send_reading(reading(0, 1), 1'b1);
    send_reading(reading(1, 1), 1'b1);
    drain_results();

    program_regs(mk_cfg(65535, 65535, -32768, 32767, -4000, 12500, 1'b1));
    send_reading(reading(0, 1), 1'b1);
    send_reading(reading(65535, 1), 1'b1);
    send_reading(reading(12345, 0), 1'b1);
    drain_results();

    // crossed limits, first a failed read to re-clamp the held value
    program_regs(mk_cfg(32757, 23153, -8711, 2868, 1000, -1000, 1'b1));
    send_reading(reading(0, 0), 1'b1);
    send_reading(reading(27898, 1), 1'b1);
    send_reading(reading(10000, 1), 1'b1);
    send_reading(reading(60000, 1), 1'b1);
    drain_results();

    for (ph = 0; ph < RandPhases; ph++) begin
      last_ph = (ph == RandPhases - 1);
      kind = $urandom_range(0, 2);
      c = rand_cal(kind, ph != 1);
      tx_idle_en = !last_ph && ($urandom_range(0, 3) != 0);
      rx_idle_en = !last_ph && ($urandom_range(0, 3) != 0);
      program_regs(c);
      n = (ph == 1) ? 20 : PhaseItems;
      if (ph == 3) long_hold_req = 1'b1;
      for (i = 0; i < n; i++) begin
        // back to back while the receiver holds off so the block backs up
        send_reading(rand_reading(kind, c), !(ph == 3 && i < 16));
        if (ph == 5 && i == n / 2) wait_results();
      end
      drain_results();
    end

    $display("checked %0d results over %0d calibration settings: %0d fresh, %0d repeated, %0d divide faults",
             sb.results_seen, settings_used, sb.fresh_seen, sb.results_seen - sb.fresh_seen,
             sb.fault_seen);
    $display("mismatches %0d, results still owed %0d", sb.mismatches, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
